[rtl/tbme_pkg.sv]
// Package for the three-bit machine execute block.
// Holds the item types, opcode and operand codes and fixed widths.
// Has no dependencies; every module of the block but tbme_fifo imports it.
package tbme_pkg;

    localparam int OP_BITS        = 3;
    localparam int PC_BITS        = 8;
    localparam int NEXT_PC_BITS   = 9;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int MAX_WORD_BITS  = 64;
    localparam int PC_STEP        = 2;

    localparam logic REQ_RESTART = 1'b0;
    localparam logic REQ_EXEC    = 1'b1;

    localparam logic [OP_BITS-1:0] OP_ADV = 3'd0;
    localparam logic [OP_BITS-1:0] OP_BXL = 3'd1;
    localparam logic [OP_BITS-1:0] OP_BST = 3'd2;
    localparam logic [OP_BITS-1:0] OP_JNZ = 3'd3;
    localparam logic [OP_BITS-1:0] OP_BXC = 3'd4;
    localparam logic [OP_BITS-1:0] OP_OUT = 3'd5;
    localparam logic [OP_BITS-1:0] OP_BDV = 3'd6;
    localparam logic [OP_BITS-1:0] OP_CDV = 3'd7;

    localparam logic [OP_BITS-1:0] COMBO_REG_A = 3'd4;
    localparam logic [OP_BITS-1:0] COMBO_REG_B = 3'd5;
    localparam logic [OP_BITS-1:0] COMBO_REG_C = 3'd6;
    localparam logic [OP_BITS-1:0] COMBO_BAD   = 3'd7;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_A = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_B = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_C = 2'd2;

    typedef struct packed {
        logic               restart;
        logic [OP_BITS-1:0] opcode;
        logic [OP_BITS-1:0] operand;
        logic [PC_BITS-1:0] pc;
        logic               bad_operand;
    } tbme_item_t;

    typedef struct packed {
        logic [NEXT_PC_BITS-1:0] next_pc;
        logic                    out_valid;
        logic [OP_BITS-1:0]      out_digit;
        logic                    bad_operand;
    } tbme_result_t;

    typedef struct packed {
        logic                      valid;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
    } tbme_cfg_wr_t;

endpackage

[rtl/three_bit_machine_execute.sv]
// Three-bit machine execute unit: each item restarts the machine or runs one instruction on
// registers A, B and C, and every item yields exactly one result item. An item passes through
// the item queue to the execute stage, which pushes its result into the result queue; one item
// per cycle is sustained while items are queued and the result queue has room, with a barrel
// shifter on A in the execute stage. Two-entry queues sit between the front stage and the
// execute stage and in front of the result ports, so either side may stall independently.
// The configuration channel is always ready.
// Depends on tbme_pkg, tbme_fifo, tbme_front and tbme_back.
module three_bit_machine_execute
    import tbme_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      req_type,
    input  logic [OP_BITS-1:0]        opcode,
    input  logic [OP_BITS-1:0]        operand,
    input  logic [PC_BITS-1:0]        pc,
    output logic                      empty,
    input  logic                      pop,
    output logic [NEXT_PC_BITS-1:0]   next_pc,
    output logic                      out_valid,
    output logic [OP_BITS-1:0]        out_digit,
    output logic                      bad_operand,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    tbme_item_t   item;
    tbme_result_t result;
    tbme_result_t head;
    tbme_cfg_wr_t cfg_wr;
    logic item_empty;
    logic item_pop;
    logic res_full;
    logic res_push;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid && cfg_ready;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    tbme_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .opcode    (opcode),
        .operand   (operand),
        .pc        (pc),
        .item      (item),
        .item_empty(item_empty),
        .item_pop  (item_pop)
    );

    tbme_back #(
        .WORD_BITS(WORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .item      (item),
        .item_empty(item_empty),
        .item_pop  (item_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .result    (result)
    );

    tbme_fifo #(
        .WIDTH($bits(tbme_result_t)),
        .DEPTH(2)
    ) u_result_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (res_push),
        .wr_data(result),
        .full   (res_full),
        .pop    (pop),
        .rd_data(head),
        .empty  (empty)
    );

    assign next_pc     = head.next_pc;
    assign out_valid   = head.out_valid;
    assign out_digit   = head.out_digit;
    assign bad_operand = head.bad_operand;

endmodule

[rtl/tbme_fifo.sv]
// Small first-in first-out queue built from flip-flops.
// Used between the decode and execute stages and on the result side.
// Depends on nothing outside this file.
module tbme_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic push_ok;
    logic pop_ok;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("queue count exceeds its depth");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (push_ok && !pop_ok) |=> !empty)
        else $error("queue empty after an item was pushed");
`endif

endmodule

[rtl/tbme_front.sv]
// Front stage: accepts items, classifies them and queues them for execution.
// Depends on tbme_pkg and tbme_fifo.
module tbme_front
    import tbme_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               req_type,
    input  logic [OP_BITS-1:0] opcode,
    input  logic [OP_BITS-1:0] operand,
    input  logic [PC_BITS-1:0] pc,
    output tbme_item_t         item,
    output logic               item_empty,
    input  logic               item_pop
);

    tbme_item_t dec_item;
    logic uses_combo;

    always_comb
    begin
        case (opcode)
            OP_ADV, OP_BST, OP_OUT, OP_BDV, OP_CDV: uses_combo = 1'b1;
            default: uses_combo = 1'b0;
        endcase
    end

    always_comb
    begin
        dec_item.restart     = (req_type == REQ_RESTART);
        dec_item.opcode      = opcode;
        dec_item.operand     = operand;
        dec_item.pc          = pc;
        dec_item.bad_operand = (req_type == REQ_EXEC) && uses_combo
                               && (operand == COMBO_BAD);
    end

    tbme_fifo #(
        .WIDTH($bits(tbme_item_t)),
        .DEPTH(2)
    ) u_item_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_data(dec_item),
        .full   (full),
        .pop    (item_pop),
        .rd_data(item),
        .empty  (item_empty)
    );

endmodule

[rtl/tbme_back.sv]
// Back stage: holds A, B, C and start values; executes one item per cycle unless stalled.
// Depends on tbme_pkg.
module tbme_back
    import tbme_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  tbme_cfg_wr_t cfg_wr,
    input  tbme_item_t   item,
    input  logic         item_empty,
    output logic         item_pop,
    input  logic         res_full,
    output logic         res_push,
    output tbme_result_t result
);

    localparam int SHIFT_BITS = $clog2(WORD_BITS);
    localparam logic [WORD_BITS-1:0] WORD_LIMIT = WORD_BITS'(WORD_BITS);

    logic [WORD_BITS-1:0] start_a_reg;
    logic [WORD_BITS-1:0] start_b_reg;
    logic [WORD_BITS-1:0] start_c_reg;
    logic [WORD_BITS-1:0] a_reg;
    logic [WORD_BITS-1:0] a_next;
    logic [WORD_BITS-1:0] b_reg;
    logic [WORD_BITS-1:0] b_next;
    logic [WORD_BITS-1:0] c_reg;
    logic [WORD_BITS-1:0] c_next;
    logic [MAX_WORD_BITS-1:0] cfg_wide;
    logic [WORD_BITS-1:0] cfg_word;
    logic [WORD_BITS-1:0] combo;
    logic [WORD_BITS-1:0] shifted;
    logic [NEXT_PC_BITS-1:0] pc_plus;
    logic fire;

    assign fire     = !item_empty && !res_full;
    assign item_pop = fire;
    assign res_push = fire;
    assign cfg_wide = MAX_WORD_BITS'(cfg_wr.data);
    assign cfg_word = cfg_wide[WORD_BITS-1:0];
    assign pc_plus  = NEXT_PC_BITS'(item.pc) + NEXT_PC_BITS'(PC_STEP);

    always_comb
    begin
        case (item.operand)
            COMBO_REG_A: combo = a_reg;
            COMBO_REG_B: combo = b_reg;
            COMBO_REG_C: combo = c_reg;
            COMBO_BAD:   combo = '0;
            default:     combo = WORD_BITS'(item.operand);
        endcase
    end

    assign shifted = (combo >= WORD_LIMIT) ? '0 : (a_reg >> combo[SHIFT_BITS-1:0]);

    always_comb
    begin
        a_next             = a_reg;
        b_next             = b_reg;
        c_next             = c_reg;
        result.next_pc     = pc_plus;
        result.out_valid   = 1'b0;
        result.out_digit   = '0;
        result.bad_operand = item.bad_operand;
        if (item.restart)
        begin
            a_next = start_a_reg;
            b_next = start_b_reg;
            c_next = start_c_reg;
            result = '0;
        end
        else
        begin
            case (item.opcode)
                OP_ADV: a_next = shifted;
                OP_BXL: b_next = b_reg ^ WORD_BITS'(item.operand);
                OP_BST: b_next = WORD_BITS'(combo[OP_BITS-1:0]);
                OP_JNZ:
                begin
                    if (a_reg != '0)
                    begin
                        result.next_pc = NEXT_PC_BITS'(item.operand);
                    end
                end
                OP_BXC: b_next = b_reg ^ c_reg;
                OP_OUT:
                begin
                    result.out_valid = 1'b1;
                    result.out_digit = combo[OP_BITS-1:0];
                end
                OP_BDV: b_next = shifted;
                default: c_next = shifted;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
        end
        else if (fire)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_a_reg <= '0;
            start_b_reg <= '0;
            start_c_reg <= '0;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                CFG_START_A: start_a_reg <= cfg_word;
                CFG_START_B: start_b_reg <= cfg_word;
                CFG_START_C: start_c_reg <= cfg_word;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_restart_load: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.restart) |=> (a_reg == $past(start_a_reg))
            && (b_reg == $past(start_b_reg)) && (c_reg == $past(start_c_reg)))
        else $error("restart did not load the start values");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(a_reg) && $stable(b_reg) && $stable(c_reg))
        else $error("machine registers changed without an executed item");
`endif

endmodule
